/* sv/gde_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and month tables for the Gregorian date evaluator.
// No dependencies; imported by gregorian_date_evaluator.

package gde_pkg;

    // Month numbers.
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_MAY = 4'd5;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_JUL = 4'd7;
    localparam logic [3:0] MONTH_AUG = 4'd8;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_OCT = 4'd10;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Reciprocal of 100 scaled by 2^24, rounded up; exact for 16-bit years.
    localparam logic [17:0] RECIP_100     = 18'd167773;
    localparam int          RECIP_SHIFT   = 24;
    // Fliegel-Van Flandern constants.
    localparam logic [16:0] YEAR_BIAS     = 17'd4800;
    localparam logic [10:0] DAYS_4_YEARS  = 11'd1461;
    localparam logic [9:0]  CENTURY_BIAS  = 10'd49;
    localparam logic [25:0] JD_OFFSET     = 26'd32075;

    // Number of days in a month; zero for a month number that is out of range.
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL, MONTH_AUG, MONTH_OCT,
            MONTH_DEC: len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // The (367 * (m - 2 - 12t)) / 12 term, with January and February counted
    // as months 11 and 12 of the previous year.
    function automatic logic [8:0] month_term(input logic [3:0] month);
        logic [8:0] term;
        case (month)
            MONTH_MAR: term = 9'd30;
            MONTH_APR: term = 9'd61;
            MONTH_MAY: term = 9'd91;
            MONTH_JUN: term = 9'd122;
            MONTH_JUL: term = 9'd152;
            MONTH_AUG: term = 9'd183;
            MONTH_SEP: term = 9'd214;
            MONTH_OCT: term = 9'd244;
            MONTH_NOV: term = 9'd275;
            MONTH_DEC: term = 9'd305;
            MONTH_JAN: term = 9'd336;
            MONTH_FEB: term = 9'd367;
            default:   term = 9'd0;
        endcase
        return term;
    endfunction

endpackage

/* sv/gregorian_date_evaluator.sv */
`timescale 1ns / 1ps
// Gregorian date evaluator: leap flag, validity, weekday and Julian day number.
// Depends on gde_pkg for month tables and arithmetic constants.
// An accepted date passes stages 1 to 5 and the output stage before its strobe.
// Throughput: one date per cycle; busy is high only while reset is asserted.
// The six-stage pipeline never stalls, since the receiver takes every result.
// Reset (synchronous, active low) clears the stage valid bits and the strobe.

module gregorian_date_evaluator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [15:0] i_year,
    output logic        o_strobe,
    output logic        o_date_valid,
    output logic        o_leap_year,
    output logic [2:0]  o_weekday,
    output logic [24:0] o_day_number
);
    import gde_pkg::*;

    // Stage valid bits for stages 1 to 5; the output stage uses the strobe register.
    logic [4:0]  r_vld;
    logic [4:0]  n_vld;

    // Stage 1: captured date.
    logic [3:0]  r_s1_month;
    logic [4:0]  r_s1_day;
    logic [15:0] r_s1_year;

    // Stage 2: century quotient and the four-year day term.
    logic [3:0]  r_s2_month;
    logic [4:0]  r_s2_day;
    logic [15:0] r_s2_year;
    logic [9:0]  r_s2_cent;
    logic [24:0] r_s2_years_days;

    // Stage 3: flags and the remaining day-number terms.
    logic        r_s3_valid;
    logic        r_s3_leap;
    logic [24:0] r_s3_years_days;
    logic [9:0]  r_s3_month_days;
    logic [9:0]  r_s3_cent_days;

    // Stage 4: day number.
    logic        r_s4_valid;
    logic        r_s4_leap;
    logic [24:0] r_s4_jd;

    // Stage 5: octal digit sum of the day number plus one.
    logic        r_s5_valid;
    logic        r_s5_leap;
    logic [24:0] r_s5_jd;
    logic [6:0]  r_s5_dsum;

    // Output registers.
    logic        r_out_strobe;
    logic        r_out_valid;
    logic        r_out_leap;
    logic [2:0]  r_out_weekday;
    logic [24:0] r_out_jd;

    // Combinational values between stages.
    logic [16:0] n_s2_shifted_year;
    logic [33:0] n_s2_recip_prod;
    logic [27:0] n_s2_year_prod;
    logic [16:0] n_s3_cent_x100;
    logic        n_s3_cent_start;
    logic        n_s3_leap;
    logic [4:0]  n_s3_len;
    logic        n_s3_early;
    logic [9:0]  n_s3_century;
    logic [11:0] n_s3_century_x3;
    logic [25:0] n_s4_sum;
    logic [26:0] n_s5_jd_ext;
    logic [5:0]  n_s5_digits;
    logic [3:0]  n_s6_fold;
    logic [2:0]  n_s6_weekday;

    // An item is taken whenever start is high outside of reset.
    assign busy  = ~i_rst_n;
    assign n_vld = {r_vld[3:0], start};

    // Valid bits and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_out_strobe <= 1'b0;
        end else begin
            r_vld        <= n_vld;
            r_out_strobe <= r_vld[4];
        end
    end

    // Stage 2: divide the year by 100 through a reciprocal, and form 1461 * Y
    // with Y = year + 4800, less one for January and February.
    always_comb begin
        n_s2_shifted_year = {1'b0, r_s1_year} + YEAR_BIAS
                          - 17'((r_s1_month <= MONTH_FEB) ? 1 : 0);
        n_s2_recip_prod   = 34'(r_s1_year) * 34'(RECIP_100);
        n_s2_year_prod    = 28'(n_s2_shifted_year) * 28'(DAYS_4_YEARS);
    end

    // Stage 3: the year divides by 100 exactly when the quotient times 100 gives
    // it back; divisible by 400 when that quotient is also a multiple of four.
    always_comb begin
        n_s3_cent_x100  = 17'(r_s2_cent) * 17'd100;
        n_s3_cent_start = (n_s3_cent_x100 == {1'b0, r_s2_year});
        n_s3_leap       = (r_s2_year[1:0] == 2'd0)
                        && (!n_s3_cent_start || (r_s2_cent[1:0] == 2'd0));
        n_s3_len        = month_len(r_s2_month, n_s3_leap);
        n_s3_early      = (r_s2_month <= MONTH_FEB);
        // (year + 4900 + t) / 100 from the quotient of the year alone.
        n_s3_century    = r_s2_cent + CENTURY_BIAS
                        - 10'((n_s3_early && n_s3_cent_start) ? 1 : 0);
        n_s3_century_x3 = 12'(n_s3_century) * 12'd3;
    end

    // Stage 4: collect the day-number terms; an invalid date reads as zero.
    always_comb begin
        n_s4_sum = {1'b0, r_s3_years_days} + 26'(r_s3_month_days)
                 - 26'(r_s3_cent_days) - JD_OFFSET;
    end

    // Stage 5: 8 is 1 modulo 7, so the octal digit sum keeps the residue.
    always_comb begin
        n_s5_jd_ext = {2'b00, r_s4_jd};
        n_s5_digits = '0;
        for (int i = 0; i < 9; i++) begin
            n_s5_digits = n_s5_digits + 6'(n_s5_jd_ext[3*i +: 3]);
        end
    end

    // Stage 6: fold once more and reduce to 0..6, Sunday first.
    always_comb begin
        n_s6_fold = 4'(r_s5_dsum[6]) + 4'(r_s5_dsum[5:3]) + 4'(r_s5_dsum[2:0]);
        if (n_s6_fold >= 4'd14) begin
            n_s6_weekday = 3'(n_s6_fold - 4'd14);
        end else if (n_s6_fold >= 4'd7) begin
            n_s6_weekday = 3'(n_s6_fold - 4'd7);
        end else begin
            n_s6_weekday = n_s6_fold[2:0];
        end
    end

    // Payload registers of all stages.
    always_ff @(posedge i_clk) begin
        r_s1_month      <= i_month;
        r_s1_day        <= i_day;
        r_s1_year       <= i_year;

        r_s2_month      <= r_s1_month;
        r_s2_day        <= r_s1_day;
        r_s2_year       <= r_s1_year;
        r_s2_cent       <= n_s2_recip_prod[RECIP_SHIFT +: 10];
        r_s2_years_days <= n_s2_year_prod[26:2];

        r_s3_valid      <= (r_s2_day != 5'd0) && (r_s2_day <= n_s3_len);
        r_s3_leap       <= n_s3_leap;
        r_s3_years_days <= r_s2_years_days;
        r_s3_month_days <= 10'(r_s2_day) + 10'(month_term(r_s2_month));
        r_s3_cent_days  <= n_s3_century_x3[11:2];

        r_s4_valid      <= r_s3_valid;
        r_s4_leap       <= r_s3_leap;
        r_s4_jd         <= r_s3_valid ? n_s4_sum[24:0] : '0;

        r_s5_valid      <= r_s4_valid;
        r_s5_leap       <= r_s4_leap;
        r_s5_jd         <= r_s4_jd;
        r_s5_dsum       <= 7'(n_s5_digits) + 7'd1;

        r_out_valid     <= r_s5_valid;
        r_out_leap      <= r_s5_leap;
        r_out_weekday   <= r_s5_valid ? n_s6_weekday : 3'd0;
        r_out_jd        <= r_s5_jd;
    end

    assign o_strobe     = r_out_strobe;
    assign o_date_valid = r_out_valid;
    assign o_leap_year  = r_out_leap;
    assign o_weekday    = r_out_weekday;
    assign o_day_number = r_out_jd;

endmodule

/* sv/gde_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the Gregorian date evaluator, with its bind statement.
// Depends only on the top level's ports; attached to gregorian_date_evaluator.

module gde_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [3:0]  i_month,
    input logic [4:0]  i_day,
    input logic [15:0] i_year,
    input logic        o_strobe,
    input logic        o_date_valid,
    input logic        o_leap_year,
    input logic [2:0]  o_weekday,
    input logic [24:0] o_day_number
);

    // Every accepted transaction produces a result strobe.
    a_accept_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_strobe)
        else $error("accepted date did not produce a result after six cycles");

    // No result appears without a matching accepted transaction.
    a_strobe_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 6))
        else $error("result strobed without a matching accepted date");

    // A year that is not a multiple of four is never reported as leap.
    a_leap_needs_four: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(i_year[1:0], 6) != 2'd0)) |-> !o_leap_year)
        else $error("leap year reported for a year not divisible by four");

    // A day of zero never forms a valid date.
    a_zero_day_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(i_day, 6) == 5'd0)) |-> !o_date_valid)
        else $error("day zero reported as a valid date");

    // Valid dates carry a real weekday and a nonzero day number.
    a_valid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_date_valid) |-> ((o_weekday <= 3'd6) && (o_day_number != 25'd0)))
        else $error("valid date with an impossible weekday or day number");

endmodule

bind gregorian_date_evaluator gde_checker u_gde_checker (.*);
